// ===== rtl/dtwa_pkg.sv =====
// ----------------------------------------------------------------------------
// Device table package
// Shared sizes, request codes, status codes and the stored entry record
// of the device table.
// ----------------------------------------------------------------------------
package dtwa_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int HW_W        = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = 48;
   localparam int IP_W        = 32;
   localparam int TIME_W      = 32;
   localparam int FLAG_W      = 8;
   localparam int CNT_W       = 6;
   localparam int CRIT_BIT    = 7;

   typedef enum logic [2:0] {
      ACT_INSERT      = 3'd0,
      ACT_FIND_ADDR   = 3'd1,
      ACT_FIND_IP     = 3'd2,
      ACT_REMOVE      = 3'd3,
      ACT_EXPIRE_ONE  = 3'd4,
      ACT_EXPIRE_ALL  = 3'd5,
      ACT_OLDEST      = 3'd6,
      ACT_READ        = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [IP_W-1:0]   ip;
      logic [TIME_W-1:0] logged_time;
      logic [TIME_W-1:0] interval;
      logic [FLAG_W-1:0] flags;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DRAIN  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

endpackage

// ===== rtl/device_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// Device table with aging
// A table of device entries keyed by hardware address, with insert, lookup,
// remove, expiry checks, oldest search and entry read.
//
// Usage: a request is taken when req_valid is high and req_stall is low.
// The block holds req_stall high from the cycle after acceptance until it
// has finished that request. One response follows each request on the rsp_
// channel and is held until rsp_valid is high with rsp_stall low.
// Entry records sit in a single-port table memory with a registered read.
// Inserts, searches, expiry sweeps and the oldest search read one entry per
// cycle over the used slots, then take a drain step and a finish step; with
// no slot used they go straight to finish, as remove does. Expire one and
// read scan their slot the same way if it is used and valid, else finish.
// The block returns to idle as the response is loaded.
// A finished response waits in the output register while the next request
// is taken; if it has not been taken when the next request finishes, that
// request stays in its last step until it is.
// Reset clears the valid and expired marks, the high-water mark and the
// response valid; the record memory itself is not cleared.
// ----------------------------------------------------------------------------
module device_table_with_aging (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_action,
   input  logic [dtwa_pkg::ADDR_W-1:0]   req_dev_address,
   input  logic [dtwa_pkg::IP_W-1:0]     req_ip_value,
   input  logic [dtwa_pkg::TIME_W-1:0]   req_send_interval,
   input  logic [dtwa_pkg::FLAG_W-1:0]   req_flag_bits,
   input  logic [dtwa_pkg::IDX_W-1:0]    req_entry_index,
   input  logic [dtwa_pkg::TIME_W-1:0]   req_now_time,
   input  logic                          req_only_critical,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [dtwa_pkg::IDX_W-1:0]    rsp_result_index,
   output logic [dtwa_pkg::CNT_W-1:0]    rsp_expired_count,
   output logic [dtwa_pkg::ADDR_W-1:0]   rsp_read_address,
   output logic [dtwa_pkg::IP_W-1:0]     rsp_read_ip
);
   import dtwa_pkg::*;

   entry_type                table_mem [TABLE_DEPTH];
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_wa;
   entry_type                mem_wd;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;

   entry_type                rd_data_ff;
   logic [IDX_W-1:0]         rd_idx_ff;
   logic                     rd_vld_ff, rd_vld_in;

   state_type                state_ff, state_in;
   logic [TABLE_DEPTH-1:0]   valid_ff, valid_in;
   logic [TABLE_DEPTH-1:0]   expired_ff, expired_in;
   logic [HW_W-1:0]          hw_ff, hw_in;

   action_type               act_ff, act_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [IP_W-1:0]          ip_ff, ip_in;
   logic [TIME_W-1:0]        intv_ff, intv_in;
   logic [FLAG_W-1:0]        flags_ff, flags_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [TIME_W-1:0]        now_ff, now_in;
   logic                     crit_ff, crit_in;
   logic                     idx_ok_ff, idx_ok_in;

   logic [IDX_W-1:0]         scan_ff, scan_in;
   logic [IDX_W-1:0]         last_ff, last_in;
   logic                     hit_ff, hit_in;
   logic [IDX_W-1:0]         hit_idx_ff, hit_idx_in;
   logic                     free_ff, free_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [TIME_W-1:0]        best_ff, best_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ADDR_W-1:0]        cap_addr_ff, cap_addr_in;
   logic [IP_W-1:0]          cap_ip_ff, cap_ip_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic [ADDR_W-1:0]        rsp_addr_ff, rsp_addr_in;
   logic [IP_W-1:0]          rsp_ip_ff, rsp_ip_in;

   logic                     rd_entry_valid;
   logic [TIME_W-1:0]        limit;
   logic                     req_usable;

   assign rd_entry_valid = valid_ff[rd_idx_ff];
   assign limit          = rd_data_ff.logged_time + {rd_data_ff.interval[TIME_W-2:0], 1'b0};
   assign req_usable     = HW_W'(req_entry_index) < hw_ff;

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      expired_in   = expired_ff;
      hw_in        = hw_ff;
      act_in       = act_ff;
      addr_in      = addr_ff;
      ip_in        = ip_ff;
      intv_in      = intv_ff;
      flags_in     = flags_ff;
      idx_in       = idx_ff;
      now_in       = now_ff;
      crit_in      = crit_ff;
      idx_ok_in    = idx_ok_ff;
      scan_in      = scan_ff;
      last_in      = last_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      best_in      = best_ff;
      count_in     = count_ff;
      cap_addr_in  = cap_addr_ff;
      cap_ip_in    = cap_ip_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in = rsp_index_ff;
      rsp_count_in = rsp_count_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_ip_in    = rsp_ip_ff;
      rd_en        = 1'b0;
      rd_addr      = scan_ff;
      mem_we       = 1'b0;
      mem_wa       = hw_ff[IDX_W-1:0];
      mem_wd       = '{address: addr_ff, ip: ip_ff, logged_time: now_ff,
                       interval: intv_ff, flags: flags_ff};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // One entry comes back from the table memory per cycle of a sweep.
      if (rd_vld_ff) begin
         case (act_ff)
            ACT_INSERT: begin
               if (rd_entry_valid && rd_data_ff.address == addr_ff && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
               end
               if (!rd_entry_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
            end
            ACT_FIND_ADDR: begin
               if (rd_entry_valid && rd_data_ff.address == addr_ff && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
               end
            end
            ACT_FIND_IP: begin
               if (rd_entry_valid && rd_data_ff.ip == ip_ff && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
               end
            end
            ACT_EXPIRE_ONE, ACT_EXPIRE_ALL: begin
               if (rd_entry_valid) begin
                  if (now_ff > limit) begin
                     if (!crit_ff || rd_data_ff.flags[CRIT_BIT]) begin
                        expired_in[rd_idx_ff] = 1'b1;
                        count_in              = count_ff + 1'b1;
                     end
                  end else begin
                     expired_in[rd_idx_ff] = 1'b0;
                  end
               end
            end
            ACT_OLDEST: begin
               if (rd_entry_valid && (!hit_ff || rd_data_ff.logged_time < best_ff)) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
                  best_in    = rd_data_ff.logged_time;
               end
            end
            ACT_READ: begin
               cap_addr_in = rd_data_ff.address;
               cap_ip_in   = rd_data_ff.ip;
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in    = action_type'(req_action);
               addr_in   = req_dev_address;
               ip_in     = req_ip_value;
               intv_in   = req_send_interval;
               flags_in  = req_flag_bits;
               idx_in    = req_entry_index;
               now_in    = req_now_time;
               crit_in   = req_only_critical;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               count_in  = '0;
               idx_ok_in = req_usable &&
                           (action_type'(req_action) == ACT_REMOVE ||
                            valid_ff[req_entry_index]);
               unique case (action_type'(req_action))
                  ACT_REMOVE: begin
                     state_in = S_FINISH;
                  end
                  ACT_EXPIRE_ONE, ACT_READ: begin
                     scan_in = req_entry_index;
                     last_in = req_entry_index;
                     if (req_usable && valid_ff[req_entry_index]) begin
                        state_in = S_SCAN;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
                  default: begin
                     scan_in = '0;
                     last_in = IDX_W'(hw_ff - HW_W'(1));
                     if (hw_ff == '0) begin
                        state_in = S_FINISH;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_en   = 1'b1;
            rd_addr = scan_ff;
            scan_in = scan_ff + 1'b1;
            if (scan_ff == last_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_index_in  = '0;
               rsp_count_in  = '0;
               rsp_addr_in   = '0;
               rsp_ip_in     = '0;
               unique case (act_ff)
                  ACT_INSERT: begin
                     if (hit_ff) begin
                        mem_we       = 1'b1;
                        mem_wa       = hit_idx_ff;
                        rsp_index_in = hit_idx_ff;
                     end else if (free_ff) begin
                        mem_we       = 1'b1;
                        mem_wa       = free_idx_ff;
                        rsp_index_in = free_idx_ff;
                     end else if (hw_ff < HW_W'(TABLE_DEPTH)) begin
                        mem_we       = 1'b1;
                        mem_wa       = hw_ff[IDX_W-1:0];
                        rsp_index_in = hw_ff[IDX_W-1:0];
                        hw_in        = hw_ff + 1'b1;
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                     if (mem_we) begin
                        valid_in[mem_wa]   = 1'b1;
                        expired_in[mem_wa] = 1'b0;
                     end
                  end
                  ACT_FIND_ADDR, ACT_FIND_IP, ACT_OLDEST: begin
                     if (hit_ff) begin
                        rsp_index_in = hit_idx_ff;
                     end else begin
                        rsp_status_in = ST_NOT_FOUND;
                     end
                  end
                  ACT_REMOVE: begin
                     if (idx_ok_ff) begin
                        valid_in[idx_ff]   = 1'b0;
                        expired_in[idx_ff] = 1'b0;
                        rsp_index_in       = idx_ff;
                     end else begin
                        rsp_status_in = ST_BAD_INDEX;
                     end
                  end
                  ACT_EXPIRE_ONE: begin
                     if (idx_ok_ff) begin
                        rsp_index_in = idx_ff;
                        rsp_count_in = count_ff;
                     end else begin
                        rsp_status_in = ST_BAD_INDEX;
                     end
                  end
                  ACT_EXPIRE_ALL: begin
                     rsp_count_in = count_ff;
                  end
                  ACT_READ: begin
                     if (idx_ok_ff) begin
                        rsp_index_in = idx_ff;
                        rsp_addr_in  = cap_addr_ff;
                        rsp_ip_in    = cap_ip_ff;
                     end else begin
                        rsp_status_in = ST_BAD_INDEX;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rd_vld_in = rd_en;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         expired_ff   <= '0;
         hw_ff        <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         expired_ff   <= expired_in;
         hw_ff        <= hw_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_addr;
      act_ff        <= act_in;
      addr_ff       <= addr_in;
      ip_ff         <= ip_in;
      intv_ff       <= intv_in;
      flags_ff      <= flags_in;
      idx_ff        <= idx_in;
      now_ff        <= now_in;
      crit_ff       <= crit_in;
      idx_ok_ff     <= idx_ok_in;
      scan_ff       <= scan_in;
      last_ff       <= last_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      best_ff       <= best_in;
      count_ff      <= count_in;
      cap_addr_ff   <= cap_addr_in;
      cap_ip_ff     <= cap_ip_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_ip_ff     <= rsp_ip_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_index  = rsp_index_ff;
   assign rsp_expired_count = rsp_count_ff;
   assign rsp_read_address  = rsp_addr_ff;
   assign rsp_read_ip       = rsp_ip_ff;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Device table with aging testbench
// Sends directed and random table requests through the request channel,
// predicts each response from a local copy of the table and checks every
// response field in order, with random request gaps and response stalls.
// ----------------------------------------------------------------------------
module tb;
   import dtwa_pkg::*;

   localparam int INSERT_WINDOW  = 10;
   localparam int RANDOM_COUNT   = 880;
   localparam int PHASE_LEN      = 110;
   localparam int POOL_SIZE      = 40;
   localparam int DRAIN_CYCLES   = 60;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      action_type        act;
      logic [ADDR_W-1:0] addr;
      logic [IP_W-1:0]   ip;
      logic [TIME_W-1:0] interval;
      logic [FLAG_W-1:0] flags;
      logic [IDX_W-1:0]  idx;
      logic [TIME_W-1:0] now;
      logic              crit;
   } dev_req_type;

   typedef struct packed {
      status_type        status;
      logic [IDX_W-1:0]  index;
      logic [CNT_W-1:0]  count;
      logic [ADDR_W-1:0] raddr;
      logic [IP_W-1:0]   rip;
   } dev_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid         = 1'b0;
   logic                req_stall;
   logic [2:0]          req_action        = '0;
   logic [ADDR_W-1:0]   req_dev_address   = '0;
   logic [IP_W-1:0]     req_ip_value      = '0;
   logic [TIME_W-1:0]   req_send_interval = '0;
   logic [FLAG_W-1:0]   req_flag_bits     = '0;
   logic [IDX_W-1:0]    req_entry_index   = '0;
   logic [TIME_W-1:0]   req_now_time      = '0;
   logic                req_only_critical = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   logic [1:0]          rsp_status;
   logic [IDX_W-1:0]    rsp_result_index;
   logic [CNT_W-1:0]    rsp_expired_count;
   logic [ADDR_W-1:0]   rsp_read_address;
   logic [IP_W-1:0]     rsp_read_ip;

   device_table_with_aging dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_dev_address   (req_dev_address),
      .req_ip_value      (req_ip_value),
      .req_send_interval (req_send_interval),
      .req_flag_bits     (req_flag_bits),
      .req_entry_index   (req_entry_index),
      .req_now_time      (req_now_time),
      .req_only_critical (req_only_critical),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_result_index  (rsp_result_index),
      .rsp_expired_count (rsp_expired_count),
      .rsp_read_address  (rsp_read_address),
      .rsp_read_ip       (rsp_read_ip)
   );

   // Local copy of the device table.
   bit                dev_valid   [TABLE_DEPTH];
   bit                dev_expired [TABLE_DEPTH];
   logic [ADDR_W-1:0] dev_addr    [TABLE_DEPTH];
   logic [IP_W-1:0]   dev_ip      [TABLE_DEPTH];
   logic [TIME_W-1:0] dev_logged  [TABLE_DEPTH];
   logic [TIME_W-1:0] dev_interval[TABLE_DEPTH];
   logic [FLAG_W-1:0] dev_flags   [TABLE_DEPTH];
   int                dev_high_water = 0;

   dev_req_type queued_req[$];
   dev_rsp_type awaited_rsp[$];
   dev_req_type drv_req;
   dev_req_type next_req;
   dev_rsp_type want_rsp;

   logic [ADDR_W-1:0] addr_pool[POOL_SIZE];
   logic [IP_W-1:0]   ip_pool[POOL_SIZE];
   logic [TIME_W-1:0] wall_clock = 32'd1000;

   bit calm = 1'b0;
   int send_gap = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int error_count = 0;
   int rsp_checked = 0;
   int act_seen[8];
   int status_seen[4];

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic bit judge_entry(int i, logic [TIME_W-1:0] now, logic crit);
      logic [TIME_W-1:0] deadline;
      deadline = dev_logged[i] + {dev_interval[i][TIME_W-2:0], 1'b0};
      if (now > deadline) begin
         if (crit && !dev_flags[i][CRIT_BIT])
            return 1'b0;
         dev_expired[i] = 1'b1;
         return 1'b1;
      end
      dev_expired[i] = 1'b0;
      return 1'b0;
   endfunction

   function automatic dev_rsp_type predict_response(dev_req_type r);
      dev_rsp_type o;
      int lim;
      int win;
      int hit;
      int cnt;
      bit found;
      logic [TIME_W-1:0] best;
      o = '0;
      o.status = ST_OK;
      lim = (dev_high_water < TABLE_DEPTH) ? dev_high_water : TABLE_DEPTH;
      hit = -1;
      cnt = 0;
      found = 1'b0;
      best = '0;
      case (r.act)
         ACT_INSERT: begin
            for (int i = 0; i < lim; i++)
               if (hit < 0 && dev_valid[i] && dev_addr[i] == r.addr)
                  hit = i;
            if (hit < 0) begin
               win = dev_high_water + INSERT_WINDOW;
               if (win > TABLE_DEPTH)
                  win = TABLE_DEPTH;
               for (int i = 0; i < win; i++)
                  if (hit < 0 && !dev_valid[i])
                     hit = i;
               if (hit >= 0) begin
                  dev_addr[hit] = r.addr;
                  if (hit >= dev_high_water)
                     dev_high_water = hit + 1;
               end
            end
            if (hit >= 0) begin
               dev_ip[hit]       = r.ip;
               dev_interval[hit] = r.interval;
               dev_flags[hit]    = r.flags;
               dev_logged[hit]   = r.now;
               dev_expired[hit]  = 1'b0;
               dev_valid[hit]    = 1'b1;
               o.index = IDX_W'(hit);
            end else begin
               o.status = ST_FULL;
            end
         end
         ACT_FIND_ADDR, ACT_FIND_IP: begin
            for (int i = 0; i < lim; i++)
               if (hit < 0 && dev_valid[i] &&
                   ((r.act == ACT_FIND_ADDR) ? dev_addr[i] == r.addr : dev_ip[i] == r.ip))
                  hit = i;
            if (hit >= 0)
               o.index = IDX_W'(hit);
            else
               o.status = ST_NOT_FOUND;
         end
         ACT_REMOVE: begin
            if (r.idx < lim) begin
               dev_valid[r.idx]   = 1'b0;
               dev_expired[r.idx] = 1'b0;
               o.index = r.idx;
            end else begin
               o.status = ST_BAD_INDEX;
            end
         end
         ACT_EXPIRE_ONE: begin
            if (r.idx < lim && dev_valid[r.idx]) begin
               o.count = CNT_W'(judge_entry(r.idx, r.now, r.crit));
               o.index = r.idx;
            end else begin
               o.status = ST_BAD_INDEX;
            end
         end
         ACT_EXPIRE_ALL: begin
            for (int i = 0; i < lim; i++)
               if (dev_valid[i])
                  cnt += judge_entry(i, r.now, r.crit);
            o.count = CNT_W'((cnt > 63) ? 63 : cnt);
         end
         ACT_OLDEST: begin
            for (int i = 0; i < lim; i++)
               if (dev_valid[i] && (!found || dev_logged[i] < best)) begin
                  found = 1'b1;
                  best = dev_logged[i];
                  o.index = IDX_W'(i);
               end
            if (!found)
               o.status = ST_NOT_FOUND;
         end
         default: begin
            if (r.idx < lim && dev_valid[r.idx]) begin
               o.raddr = dev_addr[r.idx];
               o.rip   = dev_ip[r.idx];
               o.index = r.idx;
            end else begin
               o.status = ST_BAD_INDEX;
            end
         end
      endcase
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic dev_req_type make_req(action_type a, logic [ADDR_W-1:0] addr,
                                            logic [IP_W-1:0] ip, logic [TIME_W-1:0] intv,
                                            logic [FLAG_W-1:0] flags, logic [IDX_W-1:0] idx,
                                            logic [TIME_W-1:0] now, logic crit);
      dev_req_type r;
      r.act      = a;
      r.addr     = addr;
      r.ip       = ip;
      r.interval = intv;
      r.flags    = flags;
      r.idx      = idx;
      r.now      = now;
      r.crit     = crit;
      return r;
   endfunction

   function automatic dev_req_type rand_req(action_type a);
      dev_req_type r;
      int k;
      r.act = a;
      if ($urandom_range(0, 99) < 85)
         r.addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
         r.addr = ADDR_W'({$urandom, $urandom});
      if ($urandom_range(0, 9) < 8)
         r.ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
         r.ip = $urandom;
      k = $urandom_range(0, 9);
      if (k < 6)
         r.interval = $urandom_range(0, 50);
      else if (k < 9)
         r.interval = $urandom_range(0, 1000);
      else
         r.interval = $urandom;
      r.flags = FLAG_W'($urandom_range(0, 255));
      r.idx   = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
      wall_clock = wall_clock + $urandom_range(0, 40);
      r.now  = ($urandom_range(0, 9) == 0) ? $urandom : wall_clock;
      r.crit = ($urandom_range(0, 3) == 0);
      return r;
   endfunction

   task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_rsp.push_back(predict_response(drv_req));
            act_seen[drv_req.act]++;
            if ($urandom_range(0, 79) == 0)
               calm <= !calm;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0 || queued_req.size() == 0) begin
               req_valid <= 1'b0;
               if (send_gap > 0)
                  send_gap <= send_gap - 1;
            end else begin
               next_req = queued_req.pop_front();
               drv_req           <= next_req;
               req_valid         <= 1'b1;
               req_action        <= next_req.act;
               req_dev_address   <= next_req.addr;
               req_ip_value      <= next_req.ip;
               req_send_interval <= next_req.interval;
               req_flag_bits     <= next_req.flags;
               req_entry_index   <= next_req.idx;
               req_now_time      <= next_req.now;
               req_only_critical <= next_req.crit;
               send_gap          <= pick_gap();
            end
         end
      end
   end

   // Response monitor and stall generator.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: response with none expected, status %0d index %0d",
                        $time, rsp_status, rsp_result_index);
               error_count++;
            end else begin
               want_rsp = awaited_rsp.pop_front();
               check_field("status", want_rsp.status, rsp_status);
               check_field("result_index", want_rsp.index, rsp_result_index);
               check_field("expired_count", want_rsp.count, rsp_expired_count);
               check_field("read_address", want_rsp.raddr, rsp_read_address);
               check_field("read_ip", want_rsp.rip, rsp_read_ip);
               status_seen[want_rsp.status]++;
               rsp_checked++;
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
               hold_left <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int phase;
      int r;
      int ins_pct;
      int rem_pct;
      action_type a;

      for (int i = 0; i < POOL_SIZE; i++) begin
         addr_pool[i] = ADDR_W'({$urandom, $urandom});
         ip_pool[i]   = $urandom;
      end
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      ip_pool[0]   = '0;
      ip_pool[1]   = '1;

      // Empty table, then extremes, updates, wrapped deadlines and bad indexes.
      queued_req.push_back(make_req(ACT_OLDEST, 0, 0, 0, 0, 0, 0, 0));
      queued_req.push_back(make_req(ACT_FIND_ADDR, 0, 0, 0, 0, 0, 0, 0));
      queued_req.push_back(make_req(ACT_FIND_IP, 0, 0, 0, 0, 0, 0, 0));
      queued_req.push_back(make_req(ACT_READ, 0, 0, 0, 0, 0, 0, 0));
      queued_req.push_back(make_req(ACT_REMOVE, 0, 0, 0, 0, 31, 0, 0));
      queued_req.push_back(make_req(ACT_EXPIRE_ONE, 0, 0, 0, 0, 0, 0, 0));
      queued_req.push_back(make_req(ACT_EXPIRE_ALL, 0, 0, 0, 0, 0, '1, 1));
      queued_req.push_back(make_req(ACT_INSERT, 0, 0, 0, 0, 0, 100, 0));
      queued_req.push_back(make_req(ACT_INSERT, '1, '1, '1, '1, '1, '1, 1));
      queued_req.push_back(make_req(ACT_INSERT, 0, 32'h0A00_0001, 5, 8'h80, 0, 100, 0));
      queued_req.push_back(make_req(ACT_INSERT, 48'h0123_4567_89AB, 32'hC0A8_0001, 32'h10,
                                    8'h7F, 0, 32'hFFFF_FFF0, 0));
      queued_req.push_back(make_req(ACT_FIND_ADDR, '1, 0, 0, 0, 0, 0, 0));
      queued_req.push_back(make_req(ACT_FIND_IP, 0, 32'hC0A8_0001, 0, 0, 0, 0, 0));
      queued_req.push_back(make_req(ACT_FIND_ADDR, 48'h5, 0, 0, 0, 0, 0, 0));
      queued_req.push_back(make_req(ACT_READ, 0, 0, 0, 0, 1, 0, 0));
      queued_req.push_back(make_req(ACT_OLDEST, 0, 0, 0, 0, 0, 0, 0));
      queued_req.push_back(make_req(ACT_EXPIRE_ONE, 0, 0, 0, 0, 2, 32'h21, 0));
      queued_req.push_back(make_req(ACT_EXPIRE_ALL, 0, 0, 0, 0, 0, 200, 1));
      queued_req.push_back(make_req(ACT_EXPIRE_ALL, 0, 0, 0, 0, 0, 50, 0));
      queued_req.push_back(make_req(ACT_REMOVE, 0, 0, 0, 0, 1, 0, 0));
      queued_req.push_back(make_req(ACT_REMOVE, 0, 0, 0, 0, 1, 0, 0));
      queued_req.push_back(make_req(ACT_READ, 0, 0, 0, 0, 1, 0, 0));
      queued_req.push_back(make_req(ACT_EXPIRE_ONE, 0, 0, 0, 0, 1, '1, 0));
      queued_req.push_back(make_req(ACT_REMOVE, 0, 0, 0, 0, 5, 0, 0));
      queued_req.push_back(make_req(ACT_INSERT, 48'h2, 32'h2, 3, 8'h01, 0, 100, 0));
      queued_req.push_back(make_req(ACT_OLDEST, 0, 0, 0, 0, 0, 0, 0));

      // Random phases: filling, mixed traffic, draining and aging.
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         phase = (n / PHASE_LEN) % 4;
         case (phase)
            0: begin ins_pct = 60; rem_pct = 5;  end
            1: begin ins_pct = 30; rem_pct = 10; end
            2: begin ins_pct = 10; rem_pct = 40; end
            default: begin ins_pct = 25; rem_pct = 10; end
         endcase
         r = $urandom_range(0, 99);
         if (r < ins_pct) begin
            a = ACT_INSERT;
         end else if (r < ins_pct + rem_pct) begin
            a = ACT_REMOVE;
         end else begin
            case ($urandom_range(0, 5))
               0: a = ACT_FIND_ADDR;
               1: a = ACT_FIND_IP;
               2: a = ACT_EXPIRE_ONE;
               3: a = ACT_EXPIRE_ALL;
               4: a = ACT_OLDEST;
               default: a = ACT_READ;
            endcase
         end
         queued_req.push_back(rand_req(a));
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (queued_req.size() != 0 || req_valid || awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (awaited_rsp.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, awaited_rsp.size());
         error_count++;
      end

      $display("Covered %0d responses: insert %0d, find %0d, remove %0d, expire %0d,",
               rsp_checked, act_seen[ACT_INSERT], act_seen[ACT_FIND_ADDR] + act_seen[ACT_FIND_IP],
               act_seen[ACT_REMOVE], act_seen[ACT_EXPIRE_ONE] + act_seen[ACT_EXPIRE_ALL]);
      $display("oldest %0d, read %0d; status mix: ok %0d, not found %0d, full %0d, bad index %0d.",
               act_seen[ACT_OLDEST], act_seen[ACT_READ],
               status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_FULL],
               status_seen[ST_BAD_INDEX]);

      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
